>>> rtl/core/lbv_pkg.sv
// package for the lorentz boost vector block
// widths of the fixed-point datapath and the payload that travels beside it
// no dependencies
`timescale 1ns / 1ps

package lbv_pkg;

  // input and output formats
  localparam int BETA_FRAC  = 30;
  localparam int BETA_W     = BETA_FRAC + 1;
  localparam int ENERGY_W   = 48;
  localparam int EN_W       = ENERGY_W - 1;
  localparam int GAMMA_FRAC = 62 - BETA_FRAC;

  // beta squared and the gamma divider
  localparam int SQ_W        = 2 * BETA_W;
  localparam int D_W         = 2 * BETA_FRAC + 1;
  localparam int NUM_EXP     = 124;
  localparam int DIV1_STAGES = NUM_EXP + 1;
  localparam int Q1_W        = DIV1_STAGES;

  // square root of the quotient
  localparam int SQRT_STAGES = (Q1_W + 1) / 2;
  localparam int RAD_W       = 2 * SQRT_STAGES;
  localparam int G_W         = SQRT_STAGES;
  localparam int SR_W        = G_W + 2;

  // c = g^2 / (g + 1)
  localparam int N_W         = 2 * G_W - 1;
  localparam int DIV2_STAGES = G_W;
  localparam int HALF        = 32;

  // beta dot p and the boost arithmetic
  localparam int PL_W  = HALF - 7 + BETA_W;
  localparam int PH_W  = ENERGY_W - 24 + BETA_W;
  localparam int PR_W  = ENERGY_W + BETA_W;
  localparam int BS_W  = PR_W + 2;
  localparam int BP_W  = BS_W - BETA_FRAC;
  localparam int K_W   = 80;

  // multiplier widths, used by every lbv_mul instance
  localparam int MA_W = 96;
  localparam int MB_W = 64;
  localparam int MP_W = MA_W + MB_W;

  typedef struct packed {
    logic [2:0][BETA_W-1:0]   beta;
    logic [2:0][ENERGY_W-1:0] mom;
    logic [EN_W-1:0]          energy;
    logic [EN_W-1:0]          mass;
    logic [BP_W-1:0]          bp;
    logic                     bypass;
    logic                     invalid;
  } side_t;

endpackage

>>> rtl/core/lorentz_boost_vector.sv
// lorentz boost of one particle along an arbitrary velocity, top level
// depends on lbv_pkg, lbv_gamma and lbv_mul
//
// Usage:
// - input channel: in_valid/in_ready with the boost velocity (beta_x/y/z, 30
//   fractional bits) and energy, momentum and mass (24 fractional bits)
// - output channel: out_valid/out_ready with boosted energy, momentum and the
//   invalid_boost flag (beta squared of one or more, item passed unchanged)
// - a zero velocity passes the item unchanged with invalid_boost low
// - one transfer per cycle is taken and one result per cycle is given while
//   results are taken; the bit-per-stage divider and square root that form
//   gamma make up most of the pipeline stages
// - the pipeline is one chain of stages with valid bits; when the output
//   register holds a result that is not taken, the whole chain freezes and
//   in_ready drops, nothing is lost or repeated
// - reset clears every valid bit; data registers are not reset
`timescale 1ns / 1ps

module lorentz_boost_vector (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [lbv_pkg::BETA_W-1:0]   beta_x,
  input  logic signed [lbv_pkg::BETA_W-1:0]   beta_y,
  input  logic signed [lbv_pkg::BETA_W-1:0]   beta_z,
  input  logic [lbv_pkg::EN_W-1:0]            energy_in,
  input  logic signed [lbv_pkg::ENERGY_W-1:0] mom_x_in,
  input  logic signed [lbv_pkg::ENERGY_W-1:0] mom_y_in,
  input  logic signed [lbv_pkg::ENERGY_W-1:0] mom_z_in,
  input  logic [lbv_pkg::EN_W-1:0]            rest_mass,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lbv_pkg::EN_W-1:0]            energy_out,
  output logic signed [lbv_pkg::ENERGY_W-1:0] mom_x_out,
  output logic signed [lbv_pkg::ENERGY_W-1:0] mom_y_out,
  output logic signed [lbv_pkg::ENERGY_W-1:0] mom_z_out,
  output logic                                invalid_boost
);
  import lbv_pkg::*;

  logic adv;

  // the whole chain moves when the output register is free or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 0: input registers
  logic                v0;
  logic [BETA_W-1:0]   b0 [3];
  logic [ENERGY_W-1:0] p0 [3];
  logic [EN_W-1:0]     e0, m0;

  // stage 1: squares and partial products of beta.p
  logic                v1;
  logic [BETA_W-1:0]   b1 [3];
  logic [ENERGY_W-1:0] p1 [3];
  logic [EN_W-1:0]     e1, m1;
  logic signed [SQ_W-1:0] sq1 [3];
  logic signed [PL_W-1:0] pl1 [3];
  logic signed [PH_W-1:0] ph1 [3];

  // stage 2: beta squared and full products
  logic                v2;
  logic [BETA_W-1:0]   b2 [3];
  logic [ENERGY_W-1:0] p2 [3];
  logic [EN_W-1:0]     e2, m2;
  logic [SQ_W-1:0]     s2;
  logic signed [PR_W-1:0] pr2 [3];

  // stage 3: beta.p, special cases and the divisor 1 - beta^2
  logic                v3;
  logic [D_W-1:0]      den3;
  side_t               side3;
  logic signed [BS_W-1:0] bsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_comb begin
    bsum = {{2{pr2[0][PR_W-1]}}, pr2[0]} + {{2{pr2[1][PR_W-1]}}, pr2[1]}
           + {{2{pr2[2][PR_W-1]}}, pr2[2]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0[0] <= beta_x;
      b0[1] <= beta_y;
      b0[2] <= beta_z;
      p0[0] <= mom_x_in;
      p0[1] <= mom_y_in;
      p0[2] <= mom_z_in;
      e0    <= energy_in;
      m0    <= rest_mass;

      for (int i = 0; i < 3; i++) begin
        b1[i]  <= b0[i];
        p1[i]  <= p0[i];
        sq1[i] <= $signed(b0[i]) * $signed(b0[i]);
        pl1[i] <= $signed({1'b0, p0[i][23:0]}) * $signed(b0[i]);
        ph1[i] <= $signed(p0[i][ENERGY_W-1:24]) * $signed(b0[i]);
      end
      e1 <= e0;
      m1 <= m0;

      for (int i = 0; i < 3; i++) begin
        b2[i]  <= b1[i];
        p2[i]  <= p1[i];
        pr2[i] <= $signed({ph1[i], 24'd0})
                  + $signed({{(PR_W-PL_W){pl1[i][PL_W-1]}}, pl1[i]});
      end
      e2 <= e1;
      m2 <= m1;
      s2 <= SQ_W'(sq1[0]) + SQ_W'(sq1[1]) + SQ_W'(sq1[2]);

      for (int i = 0; i < 3; i++) begin
        side3.beta[i] <= b2[i];
        side3.mom[i]  <= p2[i];
      end
      side3.energy  <= e2;
      side3.mass    <= m2;
      side3.bp      <= bsum[BS_W-1:BETA_FRAC];
      side3.bypass  <= (s2 == '0) || (s2 >= (SQ_W'(1) << (2 * BETA_FRAC)));
      side3.invalid <= s2 >= (SQ_W'(1) << (2 * BETA_FRAC));
      den3          <= D_W'((SQ_W'(1) << (2 * BETA_FRAC)) - s2);
    end
  end

  // gamma and c
  logic           gv;
  logic [G_W-1:0] gam, coef;
  side_t          gside;

  lbv_gamma u_gamma (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v3),
    .in_den    (den3),
    .in_side   (side3),
    .out_valid (gv),
    .out_gamma (gam),
    .out_coef  (coef),
    .out_side  (gside)
  );

  // first multiplier bank: (E - bp)*g, E*g, bp*c
  logic signed [MA_W-1:0] e_ext, bp_ext, x1;
  logic signed [MB_W-1:0] g_ext, c_ext;
  logic signed [MP_W-1:0] prod_e, prod_ge, prod_cb;

  always_comb begin
    e_ext  = {{(MA_W-EN_W){1'b0}}, gside.energy};
    bp_ext = {{(MA_W-BP_W){gside.bp[BP_W-1]}}, gside.bp};
    x1     = e_ext - bp_ext;
    g_ext  = {{(MB_W-G_W){1'b0}}, gam};
    c_ext  = {{(MB_W-G_W){1'b0}}, coef};
  end

  lbv_mul u_mul_e  (.clk(clk), .en(adv), .a(x1),     .b(g_ext), .p(prod_e));
  lbv_mul u_mul_ge (.clk(clk), .en(adv), .a(e_ext),  .b(g_ext), .p(prod_ge));
  lbv_mul u_mul_cb (.clk(clk), .en(adv), .a(bp_ext), .b(c_ext), .p(prod_cb));

  logic  ma_v1, ma_v2;
  side_t ma_side1, ma_side2;

  // stage k: boosted energy and the momentum coefficient
  logic                  vk;
  side_t                 kside;
  logic signed [K_W-1:0] newe_k, kcoef;

  always_ff @(posedge clk) begin
    if (rst) begin
      ma_v1 <= 1'b0;
      ma_v2 <= 1'b0;
      vk    <= 1'b0;
    end else if (adv) begin
      ma_v1 <= gv;
      ma_v2 <= ma_v1;
      vk    <= ma_v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma_side1 <= gside;
      ma_side2 <= ma_side1;
      kside    <= ma_side2;
      newe_k   <= prod_e[GAMMA_FRAC+K_W-1:GAMMA_FRAC];
      kcoef    <= prod_cb[GAMMA_FRAC+K_W-1:GAMMA_FRAC]
                  - prod_ge[GAMMA_FRAC+K_W-1:GAMMA_FRAC];
    end
  end

  // second multiplier bank: k * beta_i
  logic signed [MA_W-1:0] k_ext;
  logic signed [MB_W-1:0] bk_ext [3];
  logic signed [MP_W-1:0] prod_k [3];

  always_comb begin
    k_ext = {{(MA_W-K_W){kcoef[K_W-1]}}, kcoef};
    for (int i = 0; i < 3; i++) begin
      bk_ext[i] = {{(MB_W-BETA_W){kside.beta[i][BETA_W-1]}}, kside.beta[i]};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_mulk
    lbv_mul u_mul_k (.clk(clk), .en(adv), .a(k_ext), .b(bk_ext[i]), .p(prod_k[i]));
  end

  logic                  mb_v1, mb_v2;
  side_t                 mb_side1, mb_side2;
  logic signed [K_W-1:0] mb_newe1, mb_newe2;

  always_ff @(posedge clk) begin
    if (rst) begin
      mb_v1 <= 1'b0;
      mb_v2 <= 1'b0;
    end else if (adv) begin
      mb_v1 <= vk;
      mb_v2 <= mb_v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mb_side1 <= kside;
      mb_side2 <= mb_side1;
      mb_newe1 <= newe_k;
      mb_newe2 <= mb_newe1;
    end
  end

  // final stage: add momentum shift, clamp energy, saturate, pass-through
  logic signed [K_W:0]    mom_sum [3];
  logic [ENERGY_W-1:0]    mom_res [3];
  logic signed [K_W-1:0]  mass_ext, emax_ext;
  logic [EN_W-1:0]        e_res;

  always_comb begin
    mass_ext = {{(K_W-EN_W){1'b0}}, mb_side2.mass};
    emax_ext = {{(K_W-EN_W){1'b0}}, {EN_W{1'b1}}};
    if (mb_side2.bypass) begin
      e_res = mb_side2.energy;
    end else if (mb_newe2 < mass_ext) begin
      e_res = mb_side2.mass;
    end else if (mb_newe2 > emax_ext) begin
      e_res = {EN_W{1'b1}};
    end else begin
      e_res = mb_newe2[EN_W-1:0];
    end

    for (int i = 0; i < 3; i++) begin
      mom_sum[i] = {{(K_W+1-ENERGY_W){mb_side2.mom[i][ENERGY_W-1]}}, mb_side2.mom[i]}
                   + {prod_k[i][BETA_FRAC+K_W-1], prod_k[i][BETA_FRAC+K_W-1:BETA_FRAC]};
      if (mb_side2.bypass) begin
        mom_res[i] = mb_side2.mom[i];
      end else if (mom_sum[i] > $signed({{(K_W+2-ENERGY_W){1'b0}}, {(ENERGY_W-1){1'b1}}}))
      begin
        mom_res[i] = {1'b0, {(ENERGY_W-1){1'b1}}};
      end else if (mom_sum[i] < $signed({{(K_W+2-ENERGY_W){1'b1}}, {(ENERGY_W-1){1'b0}}}))
      begin
        mom_res[i] = {1'b1, {(ENERGY_W-1){1'b0}}};
      end else begin
        mom_res[i] = mom_sum[i][ENERGY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= mb_v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      energy_out    <= e_res;
      mom_x_out     <= mom_res[0];
      mom_y_out     <= mom_res[1];
      mom_z_out     <= mom_res[2];
      invalid_boost <= mb_side2.invalid;
    end
  end

endmodule

>>> rtl/core/lbv_mul.sv
// pipelined signed multiplier, 96 by 64 bits, built from 33 by 33 partial products
// two register stages: partial products, then their sum
// depends on lbv_pkg
`timescale 1ns / 1ps

module lbv_mul (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [lbv_pkg::MA_W-1:0]  a,
  input  logic signed [lbv_pkg::MB_W-1:0]  b,
  output logic signed [lbv_pkg::MP_W-1:0]  p
);
  import lbv_pkg::*;

  logic signed [32:0] a0, a1, a2, b0, b1;
  logic signed [65:0] p00, p10, p01, p20, p11, p21;
  logic signed [MP_W-1:0] e00, e10, e01, e20, e11, e21;

  // split into 32-bit chunks, top chunks carry the sign
  always_comb begin
    a0 = $signed({1'b0, a[31:0]});
    a1 = $signed({1'b0, a[63:32]});
    a2 = $signed({a[MA_W-1], a[MA_W-1:64]});
    b0 = $signed({1'b0, b[31:0]});
    b1 = $signed({b[MB_W-1], b[MB_W-1:32]});
  end

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= a0 * b0;
      p10 <= a1 * b0;
      p01 <= a0 * b1;
      p20 <= a2 * b0;
      p11 <= a1 * b1;
      p21 <= a2 * b1;
    end
  end

  always_comb begin
    e00 = {{(MP_W-66){p00[65]}}, p00};
    e10 = {{(MP_W-66){p10[65]}}, p10};
    e01 = {{(MP_W-66){p01[65]}}, p01};
    e20 = {{(MP_W-66){p20[65]}}, p20};
    e11 = {{(MP_W-66){p11[65]}}, p11};
    e21 = {{(MP_W-66){p21[65]}}, p21};
  end

  // weighted sum
  always_ff @(posedge clk) begin
    if (en) begin
      p <= e00 + (e10 <<< 32) + (e01 <<< 32) + (e20 <<< 64) + (e11 <<< 64)
           + (e21 <<< 96);
    end
  end

endmodule

>>> rtl/core/lbv_gamma.sv
// gamma and c = gamma^2/(gamma+1) from 1 - beta^2, dividers and root give one bit per stage
// restoring divider, digit-by-digit square root, squarer and second divider
// depends on lbv_pkg
`timescale 1ns / 1ps

module lbv_gamma (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [lbv_pkg::D_W-1:0]     in_den,
  input  lbv_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [lbv_pkg::G_W-1:0]     out_gamma,
  output logic [lbv_pkg::G_W-1:0]     out_coef,
  output lbv_pkg::side_t              out_side
);
  import lbv_pkg::*;

  // first divider: 2^124 / den
  logic            d1_v    [0:DIV1_STAGES];
  logic [D_W-1:0]  d1_den  [0:DIV1_STAGES];
  logic [D_W-1:0]  d1_rem  [0:DIV1_STAGES];
  logic [Q1_W-1:0] d1_quo  [0:DIV1_STAGES];
  side_t           d1_side [0:DIV1_STAGES];

  assign d1_v[0]    = in_valid;
  assign d1_den[0]  = in_den;
  assign d1_rem[0]  = '0;
  assign d1_quo[0]  = '0;
  assign d1_side[0] = in_side;

  for (genvar i = 0; i < DIV1_STAGES; i++) begin : g_div1
    localparam logic BIT_IN = 1'(i == 0);
    logic [D_W:0] rem_sh;
    logic         take;

    always_comb begin
      rem_sh = {d1_rem[i], BIT_IN};
      take   = rem_sh >= {1'b0, d1_den[i]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d1_v[i+1] <= 1'b0;
      end else if (en) begin
        d1_v[i+1] <= d1_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d1_den[i+1]  <= d1_den[i];
        d1_rem[i+1]  <= take ? D_W'(rem_sh - {1'b0, d1_den[i]}) : rem_sh[D_W-1:0];
        d1_quo[i+1]  <= {d1_quo[i][Q1_W-2:0], take};
        d1_side[i+1] <= d1_side[i];
      end
    end
  end

  // integer square root of the quotient, two radicand bits per stage
  logic             sr_v    [0:SQRT_STAGES];
  logic [RAD_W-1:0] sr_rad  [0:SQRT_STAGES];
  logic [SR_W-1:0]  sr_rem  [0:SQRT_STAGES];
  logic [G_W-1:0]   sr_root [0:SQRT_STAGES];
  side_t            sr_side [0:SQRT_STAGES];

  assign sr_v[0]    = d1_v[DIV1_STAGES];
  assign sr_rad[0]  = {1'b0, d1_quo[DIV1_STAGES]};
  assign sr_rem[0]  = '0;
  assign sr_root[0] = '0;
  assign sr_side[0] = d1_side[DIV1_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    logic [SR_W+1:0] rem_sh;
    logic [SR_W-1:0] trial;
    logic            take;

    always_comb begin
      rem_sh = {sr_rem[j], sr_rad[j][RAD_W-1:RAD_W-2]};
      trial  = {sr_root[j], 2'b01};
      take   = rem_sh >= {2'b00, trial};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sr_v[j+1] <= 1'b0;
      end else if (en) begin
        sr_v[j+1] <= sr_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_rad[j+1]  <= {sr_rad[j][RAD_W-3:0], 2'b00};
        sr_rem[j+1]  <= take ? SR_W'(rem_sh - {2'b00, trial}) : rem_sh[SR_W-1:0];
        sr_root[j+1] <= {sr_root[j][G_W-2:0], take};
        sr_side[j+1] <= sr_side[j];
      end
    end
  end

  // gamma squared, split into a 32-bit low half and the high half
  logic [G_W-1:0]       gamma_sq_in;
  logic                 gs1_v, gs2_v;
  logic [2*HALF-1:0]    gs1_ll;
  logic [G_W-1:0]       gs1_lh;
  logic [2*(G_W-HALF)-1:0] gs1_hh;
  logic [G_W-1:0]       gs1_g, gs2_g;
  side_t                gs1_side, gs2_side;
  logic [N_W-1:0]       gs2_num;
  logic [G_W-1:0]       gs2_den;

  assign gamma_sq_in = sr_root[SQRT_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      gs1_v <= 1'b0;
      gs2_v <= 1'b0;
    end else if (en) begin
      gs1_v <= sr_v[SQRT_STAGES];
      gs2_v <= gs1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gs1_ll   <= gamma_sq_in[HALF-1:0] * gamma_sq_in[HALF-1:0];
      gs1_lh   <= gamma_sq_in[HALF-1:0] * gamma_sq_in[G_W-1:HALF];
      gs1_hh   <= gamma_sq_in[G_W-1:HALF] * gamma_sq_in[G_W-1:HALF];
      gs1_g    <= gamma_sq_in;
      gs1_side <= sr_side[SQRT_STAGES];
      gs2_num  <= N_W'({gs1_hh, {(2*HALF){1'b0}}})
                  + N_W'({gs1_lh, {(HALF+1){1'b0}}})
                  + N_W'(gs1_ll);
      gs2_den  <= gs1_g + (G_W'(1) << GAMMA_FRAC);
      gs2_g    <= gs1_g;
      gs2_side <= gs1_side;
    end
  end

  // second divider: quotient fits in G_W bits, so start from the top remainder
  logic           d2_v    [0:DIV2_STAGES];
  logic [G_W-1:0] d2_den  [0:DIV2_STAGES];
  logic [G_W-1:0] d2_rem  [0:DIV2_STAGES];
  logic [G_W-1:0] d2_bits [0:DIV2_STAGES];
  logic [G_W-1:0] d2_quo  [0:DIV2_STAGES];
  logic [G_W-1:0] d2_g    [0:DIV2_STAGES];
  side_t          d2_side [0:DIV2_STAGES];

  assign d2_v[0]    = gs2_v;
  assign d2_den[0]  = gs2_den;
  assign d2_rem[0]  = {1'b0, gs2_num[N_W-1:G_W]};
  assign d2_bits[0] = gs2_num[G_W-1:0];
  assign d2_quo[0]  = '0;
  assign d2_g[0]    = gs2_g;
  assign d2_side[0] = gs2_side;

  for (genvar k = 0; k < DIV2_STAGES; k++) begin : g_div2
    logic [G_W:0] rem_sh;
    logic         take;

    always_comb begin
      rem_sh = {d2_rem[k], d2_bits[k][G_W-1]};
      take   = rem_sh >= {1'b0, d2_den[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d2_v[k+1] <= 1'b0;
      end else if (en) begin
        d2_v[k+1] <= d2_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d2_den[k+1]  <= d2_den[k];
        d2_rem[k+1]  <= take ? G_W'(rem_sh - {1'b0, d2_den[k]}) : rem_sh[G_W-1:0];
        d2_bits[k+1] <= {d2_bits[k][G_W-2:0], 1'b0};
        d2_quo[k+1]  <= {d2_quo[k][G_W-2:0], take};
        d2_g[k+1]    <= d2_g[k];
        d2_side[k+1] <= d2_side[k];
      end
    end
  end

  assign out_valid = d2_v[DIV2_STAGES];
  assign out_gamma = d2_g[DIV2_STAGES];
  assign out_coef  = d2_quo[DIV2_STAGES];
  assign out_side  = d2_side[DIV2_STAGES];

endmodule

>>> verif/lbv_checker.sv
// checker for the lorentz boost vector block: watches both channels,
// predicts each boosted particle and compares it with the block's result
// depends on lbv_pkg
`timescale 1ns / 1ps

module lbv_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [lbv_pkg::BETA_W-1:0]   beta_x,
  input  logic signed [lbv_pkg::BETA_W-1:0]   beta_y,
  input  logic signed [lbv_pkg::BETA_W-1:0]   beta_z,
  input  logic [lbv_pkg::EN_W-1:0]            energy_in,
  input  logic signed [lbv_pkg::ENERGY_W-1:0] mom_x_in,
  input  logic signed [lbv_pkg::ENERGY_W-1:0] mom_y_in,
  input  logic signed [lbv_pkg::ENERGY_W-1:0] mom_z_in,
  input  logic [lbv_pkg::EN_W-1:0]            rest_mass,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [lbv_pkg::EN_W-1:0]            energy_out,
  input  logic signed [lbv_pkg::ENERGY_W-1:0] mom_x_out,
  input  logic signed [lbv_pkg::ENERGY_W-1:0] mom_y_out,
  input  logic signed [lbv_pkg::ENERGY_W-1:0] mom_z_out,
  input  logic                                invalid_boost,
  output int                                  errors,
  output int                                  pending
);
  import lbv_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [EN_W-1:0]            energy;
    logic signed [ENERGY_W-1:0] mom [3];
    logic                       invalid;
  } particle_t;

  particle_t boosted_q[$];

  localparam wide_t WIDE_MAX = {1'b0, {127{1'b1}}};
  localparam wide_t WIDE_MIN = {1'b1, {127{1'b0}}};

  // clamp an exact value to the 128-bit signed range
  function automatic wide_t clamp_wide(logic signed [191:0] v);
    if (v > 192'(WIDE_MAX)) return WIDE_MAX;
    if (v < 192'(WIDE_MIN)) return WIDE_MIN;
    return v[127:0];
  endfunction

  function automatic wide_t mul_sat(wide_t a, logic signed [63:0] b);
    logic signed [191:0] x, y;
    x = a;
    y = b;
    return clamp_wide(x * y);
  endfunction

  function automatic wide_t add_sat(wide_t a, wide_t b);
    logic signed [191:0] x, y;
    x = a;
    y = b;
    return clamp_wide(x + y);
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [63:0] r, c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (x >= 128'(c) * 128'(c)) r = c;
    end
    return r;
  endfunction

  // general-direction boost with gamma from beta squared
  function automatic particle_t boost_particle(
    logic signed [BETA_W-1:0] bx, logic signed [BETA_W-1:0] by,
    logic signed [BETA_W-1:0] bz, logic [EN_W-1:0] e,
    logic signed [ENERGY_W-1:0] px, logic signed [ENERGY_W-1:0] py,
    logic signed [ENERGY_W-1:0] pz, logic [EN_W-1:0] m);
    particle_t r;
    wide_t b [3];
    wide_t p [3];
    logic [127:0] s, one;
    logic [63:0] g, c;
    wide_t bp, newe, ge, cb, k, d, t, ew, mw;
    b[0] = bx; b[1] = by; b[2] = bz;
    p[0] = px; p[1] = py; p[2] = pz;
    s = 0;
    for (int i = 0; i < 3; i++) s += b[i] * b[i];
    one = 128'd1 << (2 * BETA_FRAC);
    ew = {81'd0, e};
    mw = {81'd0, m};
    r.invalid = (s >= one);
    // zero velocity or at least light speed: pass through
    if (s == 0 || s >= one) begin
      r.energy = e;
      for (int i = 0; i < 3; i++) r.mom[i] = p[i][ENERGY_W-1:0];
      return r;
    end
    g = 64'(isqrt((128'd1 << 124) / (one - s)));
    c = 64'((128'(g) * 128'(g)) / (128'(g) + (128'd1 << GAMMA_FRAC)));
    bp = 0;
    for (int i = 0; i < 3; i++) bp = add_sat(bp, mul_sat(p[i], 64'(b[i])));
    bp = bp >>> BETA_FRAC;
    newe = mul_sat(add_sat(ew, -bp), g) >>> GAMMA_FRAC;
    ge = mul_sat(ew, g) >>> GAMMA_FRAC;
    cb = mul_sat(bp, c) >>> GAMMA_FRAC;
    k = add_sat(cb, -ge);
    // energy clamped at the mass from below, saturated above
    if (newe < mw) newe = mw;
    if (newe > wide_t'({EN_W{1'b1}})) newe = {EN_W{1'b1}};
    r.energy = newe[EN_W-1:0];
    for (int i = 0; i < 3; i++) begin
      d = mul_sat(k, 64'(b[i])) >>> BETA_FRAC;
      t = add_sat(p[i], d);
      if (t > wide_t'({1'b0, {(ENERGY_W-1){1'b1}}}))
        r.mom[i] = {1'b0, {(ENERGY_W-1){1'b1}}};
      else if (t < -wide_t'({1'b1, {(ENERGY_W-1){1'b0}}}))
        r.mom[i] = {1'b1, {(ENERGY_W-1){1'b0}}};
      else
        r.mom[i] = t[ENERGY_W-1:0];
    end
    return r;
  endfunction

  assign pending = boosted_q.size();

  // predict on input transfer, compare on output transfer
  always @(posedge clk) begin
    particle_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (in_valid && in_ready)
        boosted_q.push_back(boost_particle(beta_x, beta_y, beta_z, energy_in,
                                           mom_x_in, mom_y_in, mom_z_in, rest_mass));
      if (out_valid && out_ready) begin
        if (boosted_q.size() == 0) begin
          $display("%t: result with nothing expected, energy %h", $time, energy_out);
          errors <= errors + 1;
        end else begin
          want = boosted_q.pop_front();
          if (want.energy !== energy_out || want.mom[0] !== mom_x_out ||
              want.mom[1] !== mom_y_out || want.mom[2] !== mom_z_out ||
              want.invalid !== invalid_boost) begin
            $display("%t: mismatch expected e=%h px=%h py=%h pz=%h inv=%b", $time,
                     want.energy, want.mom[0], want.mom[1], want.mom[2], want.invalid);
            $display("%t:          actual   e=%h px=%h py=%h pz=%h inv=%b", $time,
                     energy_out, mom_x_out, mom_y_out, mom_z_out, invalid_boost);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

>>> verif/tb_lorentz_boost_vector.sv
// testbench top for the lorentz boost vector block: directed and random
// particles with random idling on both channels, verdict from lbv_checker
// depends on lbv_pkg, lbv_checker and the block
`timescale 1ns / 1ps

module tb_lorentz_boost_vector;
  import lbv_pkg::*;

  localparam int LATENCY = 263;
  localparam int CYCLE_LIMIT = 300000;
  localparam int N_RANDOM = 1130;
  localparam int BMAX = 1073741823;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [BETA_W-1:0] beta_x = '0, beta_y = '0, beta_z = '0;
  logic [EN_W-1:0] energy_in = '0, rest_mass = '0;
  logic signed [ENERGY_W-1:0] mom_x_in = '0, mom_y_in = '0, mom_z_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [EN_W-1:0] energy_out;
  logic signed [ENERGY_W-1:0] mom_x_out, mom_y_out, mom_z_out;
  logic invalid_boost;
  int errors, pending;
  int cycles = 0;
  bit no_idle = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lorentz_boost_vector dut (.*);

  lbv_checker checker_i (.*);

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // idle stretches switch on and off now and then
  always @(posedge clk) if ($urandom_range(0, 199) == 0) no_idle <= ~no_idle;

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 8);
  endfunction

  // output side stalls a random number of cycles per result
  initial begin
    int w;
    @(negedge rst);
    forever begin
      w = idle_cycles();
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // one input transfer, then a random gap
  task automatic send_particle(int bx, int by, int bz, logic [EN_W-1:0] e,
                               logic [ENERGY_W-1:0] px, logic [ENERGY_W-1:0] py,
                               logic [ENERGY_W-1:0] pz, logic [EN_W-1:0] m);
    int w;
    beta_x <= BETA_W'(bx); beta_y <= BETA_W'(by); beta_z <= BETA_W'(bz);
    energy_in <= e; rest_mass <= m;
    mom_x_in <= px; mom_y_in <= py; mom_z_in <= pz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    w = idle_cycles();
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
  endtask

  function automatic int rand_beta(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // energy-like value, mostly moderate, sometimes the full width
  function automatic logic [ENERGY_W-1:0] rand_energy(bit signed_val);
    logic [63:0] v;
    v = rand64();
    case ($urandom_range(0, 3))
      0: v = v & ((64'd1 << ENERGY_W) - 1);
      1: v = v & ((64'd1 << 36) - 1);
      default: v = v & ((64'd1 << 32) - 1);
    endcase
    if (signed_val && $urandom_range(0, 1)) v = -v;
    return signed_val ? v[ENERGY_W-1:0] : {1'b0, v[EN_W-1:0]};
  endfunction

  localparam logic [EN_W-1:0] EN_MAX = {EN_W{1'b1}};
  localparam logic [ENERGY_W-1:0] P_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic [ENERGY_W-1:0] P_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

  initial begin
    int bx, by, bz;
    logic [EN_W-1:0] e, m;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero velocity, extreme beta, light speed, extreme fields
    send_particle(0, 0, 0, EN_MAX, P_MAX, P_MIN, 48'd1, EN_MAX);
    send_particle(BMAX, 0, 0, 47'd1 << 24, 48'd0, 48'd0, 48'd0, 47'd1 << 24);
    send_particle(-BMAX, 0, 0, EN_MAX, P_MIN, P_MAX, P_MIN, 0);
    send_particle(0, 0, BMAX, EN_MAX, P_MAX, P_MAX, P_MAX, 0);
    send_particle(BMAX, BMAX, 0, 47'd5 << 24, 48'd3 << 24, 0, 0, 0);
    send_particle(-BMAX, -BMAX, -BMAX, EN_MAX, P_MIN, P_MIN, P_MIN, EN_MAX);
    send_particle(1 << 29, 1 << 29, 1 << 29, 47'd10 << 24, 48'd3 << 24,
                  48'd4 << 24, 48'd5 << 24, 47'd9 << 24);
    send_particle(1 << 29, 0, 0, 0, 48'd1 << 30, 0, 0, EN_MAX);
    send_particle(-(1 << 29), 0, 0, 47'd1 << 40, P_MIN, 0, 0, 47'd1);
    send_particle(0, 1 << 29, 0, 0, 0, P_MAX, 0, 0);
    send_particle(1, 0, 0, 47'd1 << 30, 0, 0, 0, 0);
    send_particle(0, 0, -1, EN_MAX, P_MAX, 0, P_MIN, 0);
    send_particle(BMAX - 100, 300, -300, EN_MAX, P_MAX, P_MIN, P_MAX, 0);
    send_particle(900000000, 500000000, 0, 47'd2 << 24, 0, 48'd1 << 24, 0,
                  47'd1 << 24);
    send_particle(1 << 30, 0, 0, 47'd7, 48'd7, 48'd7, 48'd7, 47'd7);

    // random particles: mostly physical boosts, some faster than light
    for (int n = 0; n < N_RANDOM; n++) begin
      case ($urandom_range(0, 9))
        0: begin bx = 0; by = 0; bz = 0; end
        1: begin
          bx = 0; by = 0; bz = 0;
          case ($urandom_range(0, 2))
            0: bx = rand_beta(BMAX);
            1: by = rand_beta(BMAX);
            default: bz = rand_beta(BMAX);
          endcase
        end
        2, 3: begin bx = rand_beta(BMAX); by = rand_beta(BMAX); bz = rand_beta(BMAX); end
        4: begin bx = rand_beta(1000); by = rand_beta(1000); bz = rand_beta(1000); end
        default: begin
          bx = rand_beta(1 << 29); by = rand_beta(1 << 29); bz = rand_beta(1 << 29);
        end
      endcase
      e = EN_W'(rand_energy(1'b0));
      m = ($urandom_range(0, 3) == 0) ? EN_W'(rand_energy(1'b0))
                                      : e >> $urandom_range(1, 20);
      send_particle(bx, by, bz, e, rand_energy(1'b1), rand_energy(1'b1),
                    rand_energy(1'b1), m);
    end
    in_valid <= 1'b0;

    // drain the pipeline
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> lorentz_boost_vector.f
rtl/core/lbv_pkg.sv
rtl/core/lbv_mul.sv
rtl/core/lbv_gamma.sv
rtl/core/lorentz_boost_vector.sv
verif/lbv_checker.sv
verif/tb_lorentz_boost_vector.sv
